// ===== sv/stpe_pkg.sv =====
// Shared types, constants and pixel scaling for the screen transition pixel unit.
`default_nettype none

package stpe_pkg;

  // Parameter defaults
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_DIM_DEF    = 1024;

  // Port widths
  localparam int PIX_W      = 16;
  localparam int POS_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_REG_W  = 11;
  localparam int Q_W        = 9;

  // Internal widths, sized for the largest frame the registers can describe
  localparam int DIM_W = 13;              // clamped frame size
  localparam int OFS_W = 14;              // signed offsets around the centre
  localparam int LV_W  = 15;              // signed wipe line value
  localparam int SQ_W  = 25;              // squared distances and their sums
  localparam int R2P_W = SQ_W + Q_W;      // radius squared before the Q8 shift
  localparam int FRP_W = DIM_W + 1 + Q_W; // wipe front before the Q8 shift

  localparam logic [Q_W-1:0] Q_ONE  = 9'd256;
  localparam logic [Q_W-1:0] Q_HALF = 9'd128;

  typedef enum logic [1:0] {
    EFFECT_FADE,
    EFFECT_IRIS,
    EFFECT_WIPE,
    EFFECT_PASS
  } effect_t;

  typedef enum logic [1:0] {
    CORNER_NW,
    CORNER_SE,
    CORNER_SW,
    CORNER_NE
  } corner_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EFFECT,
    REG_DIRECTION,
    REG_PROGRESS,
    REG_CORNER,
    REG_WIDTH,
    REG_HEIGHT,
    REG_CENTER_X,
    REG_CENTER_Y
  } reg_idx_t;

  typedef struct packed {
    effect_t                      effect;
    logic                         dir_in;
    logic [Q_W-1:0]               progress;
    corner_t                      corner;
    logic [DIM_REG_W-1:0]         width;
    logic [DIM_REG_W-1:0]         height;
    logic signed [DIM_REG_W-1:0]  center_x;
    logic signed [DIM_REG_W-1:0]  center_y;
  } cfg_t;

  // Load enables of the five pipeline stages
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
  } pipe_en_t;

  typedef struct packed {
    effect_t                  effect;
    logic                     dir_in;
    logic [PIX_W-1:0]         px;
    logic signed [OFS_W-1:0]  dx;
    logic signed [OFS_W-1:0]  dy;
    logic [DIM_W-1:0]         dxm;
    logic [DIM_W-1:0]         dym;
    logic signed [LV_W-1:0]   lv;
    logic [DIM_W:0]           wh;
    logic [Q_W-1:0]           f;
    logic [Q_W-1:0]           p;
  } stage_a_t;

  typedef struct packed {
    effect_t                  effect;
    logic                     dir_in;
    logic [PIX_W-1:0]         px;
    logic [PIX_W-1:0]         faded;
    logic [SQ_W-1:0]          dx2;
    logic [SQ_W-1:0]          dy2;
    logic [SQ_W-1:0]          dxm2;
    logic [SQ_W-1:0]          dym2;
    logic signed [LV_W-1:0]   lv;
    logic [FRP_W-1:0]         front_prod;
    logic [Q_W-1:0]           f;
    logic [Q_W-1:0]           p;
  } stage_b_t;

  typedef struct packed {
    effect_t          effect;
    logic             dir_in;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] faded;
    logic [SQ_W-1:0]  d2;
    logic [SQ_W-1:0]  max2;
    logic             lt;
    logic             gt;
    logic [Q_W-1:0]   f;
    logic [Q_W-1:0]   p;
  } stage_c_t;

  typedef struct packed {
    effect_t          effect;
    logic             dir_in;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] faded;
    logic [SQ_W-1:0]  d2;
    logic [R2P_W-1:0] r2p;
    logic             lt;
    logic             gt;
    logic [Q_W-1:0]   p;
  } stage_d_t;

  // Scale each packed channel by a Q8 factor (RGB565, or RGB332 in the low byte)
  function automatic logic [PIX_W-1:0] scale_pixel(input logic [PIX_W-1:0] px,
                                                   input logic [Q_W-1:0]   f,
                                                   input logic             wide);
    logic [Q_W+5:0]   r_p;
    logic [Q_W+5:0]   g_p;
    logic [Q_W+5:0]   b_p;
    logic [PIX_W-1:0] res;
    if (wide) begin
      r_p = px[15:11] * f;
      g_p = px[10:5] * f;
      b_p = px[4:0] * f;
      res = {r_p[12:8], g_p[13:8], b_p[12:8]};
    end else begin
      r_p = px[7:5] * f;
      g_p = px[4:2] * f;
      b_p = px[1:0] * f;
      res = {8'h00, r_p[10:8], g_p[10:8], b_p[9:8]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/stpe_geom.sv =====
// Stage A: clamp the frame, pick the factor, and form offsets and the wipe line value.
`default_nettype none

module stpe_geom #(
  parameter int PIXEL_BITS = stpe_pkg::PIXEL_BITS_DEF,
  parameter int MAX_DIM    = stpe_pkg::MAX_DIM_DEF
) (
  input  wire logic                        clk,
  input  wire stpe_pkg::pipe_en_t          en,
  input  wire stpe_pkg::cfg_t              cfg,
  input  wire logic [stpe_pkg::PIX_W-1:0]  in_pixel,
  input  wire logic [stpe_pkg::POS_W-1:0]  in_x,
  input  wire logic [stpe_pkg::POS_W-1:0]  in_y,
  output stpe_pkg::stage_a_t               sa_r
);
  import stpe_pkg::*;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
  localparam bit               WIDE    = (PIXEL_BITS >= 16);

  logic [DIM_W-1:0]        w;
  logic [DIM_W-1:0]        h;
  logic [Q_W-1:0]          p;
  logic signed [OFS_W-1:0] cx;
  logic signed [OFS_W-1:0] cy;
  logic signed [OFS_W-1:0] ex;
  logic signed [OFS_W-1:0] ey;
  logic signed [LV_W-1:0]  xl;
  logic signed [LV_W-1:0]  yl;
  logic signed [LV_W-1:0]  wl;
  logic signed [LV_W-1:0]  hl;
  stage_a_t                sa_nxt;

  // Clamp frame size and progress
  always_comb begin
    if (cfg.width == '0) begin
      w = DIM_W'(1);
    end else if (DIM_W'(cfg.width) > DIM_MAX) begin
      w = DIM_MAX;
    end else begin
      w = DIM_W'(cfg.width);
    end
    if (cfg.height == '0) begin
      h = DIM_W'(1);
    end else if (DIM_W'(cfg.height) > DIM_MAX) begin
      h = DIM_MAX;
    end else begin
      h = DIM_W'(cfg.height);
    end
    p = (cfg.progress > Q_ONE) ? Q_ONE : cfg.progress;
  end

  // Resolve the iris centre and the far edge distances
  always_comb begin
    cx = cfg.center_x[DIM_REG_W-1] ? OFS_W'(w >> 1) : OFS_W'(cfg.center_x[DIM_REG_W-2:0]);
    cy = cfg.center_y[DIM_REG_W-1] ? OFS_W'(h >> 1) : OFS_W'(cfg.center_y[DIM_REG_W-2:0]);
    ex = OFS_W'(w) - OFS_W'(1) - cx;
    ey = OFS_W'(h) - OFS_W'(1) - cy;
    xl = LV_W'(in_x);
    yl = LV_W'(in_y);
    wl = LV_W'(w);
    hl = LV_W'(h);
  end

  // Build the stage word
  always_comb begin
    sa_nxt.effect = cfg.effect;
    sa_nxt.dir_in = cfg.dir_in;
    sa_nxt.px     = WIDE ? in_pixel : {8'h00, in_pixel[7:0]};
    sa_nxt.dx     = OFS_W'(in_x) - cx;
    sa_nxt.dy     = OFS_W'(in_y) - cy;
    sa_nxt.dxm    = (cx >= ex) ? DIM_W'(cx) : DIM_W'(ex);
    sa_nxt.dym    = (cy >= ey) ? DIM_W'(cy) : DIM_W'(ey);
    sa_nxt.wh     = {1'b0, w} + {1'b0, h};
    sa_nxt.p      = p;
    sa_nxt.f      = cfg.dir_in ? p : (Q_ONE - p);
    case (cfg.corner)
      CORNER_NW: sa_nxt.lv = xl + yl;
      CORNER_SE: sa_nxt.lv = (wl - LV_W'(1) - xl) + (hl - LV_W'(1) - yl);
      CORNER_SW: sa_nxt.lv = xl + (hl - LV_W'(1) - yl);
      CORNER_NE: sa_nxt.lv = (wl - LV_W'(1) - xl) + yl;
      default:   sa_nxt.lv = xl + yl;
    endcase
  end

  // Advance stage A
  always_ff @(posedge clk) begin
    if (en.a) begin
      sa_r <= sa_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stpe_square.sv =====
// Stages B and C: squares, fade products and wipe front, then distance sums and compares.
`default_nettype none

module stpe_square #(
  parameter int PIXEL_BITS = stpe_pkg::PIXEL_BITS_DEF
) (
  input  wire logic               clk,
  input  wire stpe_pkg::pipe_en_t en,
  input  wire stpe_pkg::stage_a_t sa,
  output stpe_pkg::stage_c_t      sc_r
);
  import stpe_pkg::*;

  localparam bit WIDE = (PIXEL_BITS >= 16);

  logic signed [2*OFS_W-1:0] dx_sq;
  logic signed [2*OFS_W-1:0] dy_sq;
  logic [2*DIM_W-1:0]        dxm_sq;
  logic [2*DIM_W-1:0]        dym_sq;
  logic [FRP_W-1:0]          frp;
  logic signed [LV_W-1:0]    front_s;
  stage_b_t                  sb_nxt;
  stage_b_t                  sb_r;
  stage_c_t                  sc_nxt;

  // Stage B: square the offsets, scale the pixel, form the front product
  always_comb begin
    dx_sq  = sa.dx * sa.dx;
    dy_sq  = sa.dy * sa.dy;
    dxm_sq = sa.dxm * sa.dxm;
    dym_sq = sa.dym * sa.dym;
    frp    = sa.wh * sa.p;

    sb_nxt.effect     = sa.effect;
    sb_nxt.dir_in     = sa.dir_in;
    sb_nxt.px         = sa.px;
    sb_nxt.faded      = scale_pixel(sa.px, sa.f, WIDE);
    sb_nxt.dx2        = dx_sq[SQ_W-1:0];
    sb_nxt.dy2        = dy_sq[SQ_W-1:0];
    sb_nxt.dxm2       = dxm_sq[SQ_W-1:0];
    sb_nxt.dym2       = dym_sq[SQ_W-1:0];
    sb_nxt.lv         = sa.lv;
    sb_nxt.front_prod = frp;
    sb_nxt.f          = sa.f;
    sb_nxt.p          = sa.p;
  end

  always_ff @(posedge clk) begin
    if (en.b) begin
      sb_r <= sb_nxt;
    end
  end

  // Stage C: sum the squares and compare the line value with the front
  always_comb begin
    front_s = LV_W'(sb_r.front_prod >> 8);

    sc_nxt.effect = sb_r.effect;
    sc_nxt.dir_in = sb_r.dir_in;
    sc_nxt.px     = sb_r.px;
    sc_nxt.faded  = sb_r.faded;
    sc_nxt.d2     = sb_r.dx2 + sb_r.dy2;
    sc_nxt.max2   = sb_r.dxm2 + sb_r.dym2;
    sc_nxt.lt     = (sb_r.lv < front_s);
    sc_nxt.gt     = (sb_r.lv > front_s);
    sc_nxt.f      = sb_r.f;
    sc_nxt.p      = sb_r.p;
  end

  always_ff @(posedge clk) begin
    if (en.c) begin
      sc_r <= sc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stpe_resolve.sv =====
// Stages D and E: scale the iris radius, then pick the output pixel per effect.
`default_nettype none

module stpe_resolve #(
  parameter int PIXEL_BITS = stpe_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire stpe_pkg::pipe_en_t         en,
  input  wire stpe_pkg::stage_c_t         sc,
  output logic [stpe_pkg::PIX_W-1:0]      pixel_r
);
  import stpe_pkg::*;

  localparam bit WIDE = (PIXEL_BITS >= 16);

  logic [R2P_W-1:0]   r2p_full;
  stage_d_t           sd_nxt;
  stage_d_t           sd_r;
  logic [R2P_W-9:0]   r2;
  logic               iris_off;
  logic [PIX_W-1:0]   half_px;
  logic [PIX_W-1:0]   pixel_nxt;

  // Stage D: radius squared times the factor
  always_comb begin
    r2p_full = sc.max2 * sc.f;

    sd_nxt.effect = sc.effect;
    sd_nxt.dir_in = sc.dir_in;
    sd_nxt.px     = sc.px;
    sd_nxt.faded  = sc.faded;
    sd_nxt.d2     = sc.d2;
    sd_nxt.r2p    = r2p_full;
    sd_nxt.lt     = sc.lt;
    sd_nxt.gt     = sc.gt;
    sd_nxt.p      = sc.p;
  end

  always_ff @(posedge clk) begin
    if (en.d) begin
      sd_r <= sd_nxt;
    end
  end

  // Stage E: select the result
  always_comb begin
    r2       = sd_r.r2p[R2P_W-1:8];
    iris_off = (!sd_r.dir_in && (r2 == '0)) || ((R2P_W-8)'(sd_r.d2) > r2);
    half_px  = scale_pixel(sd_r.px, Q_HALF, WIDE);
    case (sd_r.effect)
      EFFECT_FADE: pixel_nxt = sd_r.faded;
      EFFECT_IRIS: pixel_nxt = iris_off ? '0 : sd_r.px;
      EFFECT_WIPE: begin
        if (sd_r.lt) begin
          pixel_nxt = sd_r.dir_in ? sd_r.px : '0;
        end else if (sd_r.gt) begin
          pixel_nxt = sd_r.dir_in ? '0 : sd_r.px;
        end else if (sd_r.p != '0) begin
          pixel_nxt = half_px;
        end else begin
          pixel_nxt = sd_r.dir_in ? '0 : sd_r.px;
        end
      end
      EFFECT_PASS: pixel_nxt = sd_r.px;
      default:     pixel_nxt = sd_r.px;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.e) begin
      pixel_r <= pixel_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/screen_transition_pixel_effect_unit.sv =====
// Top level: configuration registers, pipeline control and the three stage blocks.
//
// Usage: pixels enter on the in_ channel (pixel, column, row) and leave on the
// out_ channel, one result word for every input word, in order. Both channels
// use valid/ready; a word moves when valid and ready are high at a clock edge.
// The cfg_ channel writes one register per word (cfg_index selects it).
// The pipeline stages are A (clamp, offsets), B (multipliers),
// C (sums, compares), D (radius multiply), E (select, output register).
// One pixel per clock while out_ready is high and no cfg word is pending;
// the multipliers of stages B and D set the stage depth. A stalled out_ready
// freezes words with only full stages ahead; gaps close, none lost or repeated.
// cfg_ready is high only while the pipeline is empty, and a pending cfg word
// holds off new pixels, so every pixel sees one settled configuration.
// Synchronous active-low reset empties the pipeline and loads the register
// defaults: pass through, direction out, progress 0, corner NW, 240x240 frame,
// centre at the frame middle.
`default_nettype none

module screen_transition_pixel_effect_unit #(
  parameter int PIXEL_BITS = stpe_pkg::PIXEL_BITS_DEF,
  parameter int MAX_DIM    = stpe_pkg::MAX_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [stpe_pkg::PIX_W-1:0]       in_pixel_in,
  input  wire logic [stpe_pkg::POS_W-1:0]       in_x_pos,
  input  wire logic [stpe_pkg::POS_W-1:0]       in_y_pos,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [stpe_pkg::PIX_W-1:0]            out_pixel_out,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [stpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [stpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import stpe_pkg::*;

  effect_t                     effect_r;
  logic                        dir_in_r;
  logic [Q_W-1:0]              progress_r;
  corner_t                     corner_r;
  logic [DIM_REG_W-1:0]        width_r;
  logic [DIM_REG_W-1:0]        height_r;
  logic signed [DIM_REG_W-1:0] center_x_r;
  logic signed [DIM_REG_W-1:0] center_y_r;
  cfg_t                        cfg;

  logic     v_a_r;
  logic     v_b_r;
  logic     v_c_r;
  logic     v_d_r;
  logic     v_e_r;
  logic     rdy_a;
  logic     rdy_b;
  logic     rdy_c;
  logic     rdy_d;
  logic     rdy_e;
  pipe_en_t en;

  stage_a_t sa;
  stage_c_t sc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_r   <= EFFECT_PASS;
      dir_in_r   <= 1'b0;
      progress_r <= '0;
      corner_r   <= CORNER_NW;
      width_r    <= DIM_REG_W'(240);
      height_r   <= DIM_REG_W'(240);
      center_x_r <= '1;
      center_y_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_EFFECT:    effect_r   <= effect_t'(cfg_data[1:0]);
        REG_DIRECTION: dir_in_r   <= cfg_data[0];
        REG_PROGRESS:  progress_r <= cfg_data[Q_W-1:0];
        REG_CORNER:    corner_r   <= corner_t'(cfg_data[1:0]);
        REG_WIDTH:     width_r    <= cfg_data;
        REG_HEIGHT:    height_r   <= cfg_data;
        REG_CENTER_X:  center_x_r <= cfg_data;
        REG_CENTER_Y:  center_y_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_comb begin
    cfg.effect   = effect_r;
    cfg.dir_in   = dir_in_r;
    cfg.progress = progress_r;
    cfg.corner   = corner_r;
    cfg.width    = width_r;
    cfg.height   = height_r;
    cfg.center_x = center_x_r;
    cfg.center_y = center_y_r;
  end

  // Stage ready chain: a stage loads when it is empty or its successor loads
  assign rdy_e = !v_e_r || out_ready;
  assign rdy_d = !v_d_r || rdy_e;
  assign rdy_c = !v_c_r || rdy_d;
  assign rdy_b = !v_b_r || rdy_c;
  assign rdy_a = !v_a_r || rdy_b;

  always_comb begin
    en.a = rdy_a;
    en.b = rdy_b;
    en.c = rdy_c;
    en.d = rdy_d;
    en.e = rdy_e;
  end

  assign in_ready  = rdy_a && !cfg_valid;
  assign cfg_ready = !(v_a_r || v_b_r || v_c_r || v_d_r || v_e_r);
  assign out_valid = v_e_r;

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
    end else begin
      if (rdy_a) v_a_r <= in_valid && in_ready;
      if (rdy_b) v_b_r <= v_a_r;
      if (rdy_c) v_c_r <= v_b_r;
      if (rdy_d) v_d_r <= v_c_r;
      if (rdy_e) v_e_r <= v_d_r;
    end
  end

  stpe_geom #(
    .PIXEL_BITS (PIXEL_BITS),
    .MAX_DIM    (MAX_DIM)
  ) u_geom (
    .clk      (clk),
    .en       (en),
    .cfg      (cfg),
    .in_pixel (in_pixel_in),
    .in_x     (in_x_pos),
    .in_y     (in_y_pos),
    .sa_r     (sa)
  );

  stpe_square #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_square (
    .clk  (clk),
    .en   (en),
    .sa   (sa),
    .sc_r (sc)
  );

  stpe_resolve #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_resolve (
    .clk     (clk),
    .en      (en),
    .sc      (sc),
    .pixel_r (out_pixel_out)
  );

`ifndef SYNTHESIS
  a_accept_enters_a: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_a_r)
    else $error("accepted pixel did not reach stage A");

  a_d_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v_d_r && rdy_e) |=> out_valid)
    else $error("stage D word lost on its way to the output");

  a_cfg_isolated: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> (!out_valid && !(in_valid && in_ready)))
    else $error("configuration write overlapped pixel traffic");

  a_narrow_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (PIXEL_BITS < 16)) |-> (out_pixel_out[PIX_W-1:8] == 8'h00))
    else $error("high byte set in eight-bit pixel format");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_screen_transition_pixel_effect_unit.sv =====
// Self-checking testbench for the screen transition pixel effect unit.
module tb_screen_transition_pixel_effect_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import stpe_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_DIM     = MAX_DIM_DEF;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } pixel_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic [POS_W-1:0]      in_x_pos    = '0;
  logic [POS_W-1:0]      in_y_pos    = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  // Shadow copy of the transition registers, at their reset values
  effect_t                m_effect = EFFECT_PASS;
  logic                   m_dir    = 1'b0;
  logic [Q_W-1:0]         m_prog   = '0;
  corner_t                m_corner = CORNER_NW;
  logic [DIM_REG_W-1:0]   m_width  = 11'd240;
  logic [DIM_REG_W-1:0]   m_height = 11'd240;
  logic signed [10:0]     m_cx     = -11'sd1;
  logic signed [10:0]     m_cy     = -11'sd1;

  pixel_word_t      pending_words[$];
  logic [PIX_W-1:0] expected_pixels[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  // Receiver hold-off: the stimulus bumps the request count, the counter runs here
  int hold_req_seq = 0;
  int hold_ack_seq = 0;
  int hold_len     = 0;
  int hold_left    = 0;

  screen_transition_pixel_effect_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .in_x_pos      (in_x_pos),
    .in_y_pos      (in_y_pos),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // Saturate a frame dimension register to 1..MAX_DIM
  function automatic longint clamp_dim(input logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Scale each RGB565 channel by a Q8 factor
  function automatic logic [PIX_W-1:0] shade_pixel(input logic [PIX_W-1:0] px,
                                                   input longint f);
    longint r;
    longint g;
    longint b;
    r = px[15:11];
    g = px[10:5];
    b = px[4:0];
    r = (r * f) >> 8;
    g = (g * f) >> 8;
    b = (b * f) >> 8;
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  // Transition output for one pixel under the current shadow registers
  function automatic logic [PIX_W-1:0] predict_pixel(input logic [PIX_W-1:0] px,
                                                     input logic [POS_W-1:0] xp,
                                                     input logic [POS_W-1:0] yp);
    longint x;
    longint y;
    longint p;
    longint f;
    longint w;
    longint h;
    longint cx;
    longint cy;
    longint dxm;
    longint dym;
    longint r2;
    longint dx;
    longint dy;
    longint front;
    longint lv;
    logic [PIX_W-1:0] res;
    x = xp;
    y = yp;
    p = (m_prog > 9'd256) ? 256 : m_prog;
    f = m_dir ? p : 256 - p;
    w = clamp_dim(m_width);
    h = clamp_dim(m_height);
    res = px;
    case (m_effect)
      EFFECT_FADE: res = shade_pixel(px, f);
      EFFECT_IRIS: begin
        cx = m_cx;
        cy = m_cy;
        if (cx < 0) cx = w / 2;
        if (cy < 0) cy = h / 2;
        dxm = (cx >= w - 1 - cx) ? cx : w - 1 - cx;
        dym = (cy >= h - 1 - cy) ? cy : h - 1 - cy;
        r2 = ((dxm * dxm + dym * dym) * f) / 256;
        dx = x - cx;
        dy = y - cy;
        if ((!m_dir && r2 == 0) || dx * dx + dy * dy > r2) res = '0;
      end
      EFFECT_WIPE: begin
        front = ((w + h) * p) / 256;
        case (m_corner)
          CORNER_NW: lv = x + y;
          CORNER_SE: lv = (w - 1 - x) + (h - 1 - y);
          CORNER_SW: lv = x + (h - 1 - y);
          default:   lv = (w - 1 - x) + y;
        endcase
        if (lv < front) begin
          if (!m_dir) res = '0;
        end else if (lv > front) begin
          if (m_dir) res = '0;
        end else if (p > 0) begin
          res = shade_pixel(px, Q_HALF);
        end else if (m_dir) begin
          res = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random pixel, biased toward the frame, the iris centre and the wipe front
  function automatic pixel_word_t make_word();
    pixel_word_t wd;
    longint w;
    longint h;
    longint p;
    longint front;
    longint ax;
    longint by;
    longint yi;
    wd.px = $urandom_range(16'hFFFF);
    wd.x  = $urandom_range(1023);
    wd.y  = $urandom_range(1023);
    w = clamp_dim(m_width);
    h = clamp_dim(m_height);
    p = (m_prog > 9'd256) ? 256 : m_prog;
    case ($urandom_range(9))
      0, 1: ;
      2: begin
        wd.x = (m_cx < 0) ? w / 2 : m_cx;
        wd.y = (m_cy < 0) ? h / 2 : m_cy;
      end
      3, 4: begin
        front = ((w + h) * p) / 256;
        ax = wd.x;
        if (m_corner == CORNER_SE || m_corner == CORNER_NE) ax = w - 1 - ax;
        by = front - ax;
        yi = (m_corner == CORNER_NW || m_corner == CORNER_NE) ? by : h - 1 - by;
        if (yi >= 0 && yi <= 1023) wd.y = yi;
      end
      default: begin
        wd.x = $urandom_range(w - 1);
        wd.y = $urandom_range(h - 1);
      end
    endcase
    return wd;
  endfunction

  function automatic logic [DIM_REG_W-1:0] pick_dim();
    case ($urandom_range(7))
      0:       return 11'd0;
      1:       return 11'd1;
      2:       return 11'd1024;
      3:       return 11'd2047;
      4:       return $urandom_range(2047, 1025);
      5:       return $urandom_range(16, 2);
      default: return $urandom_range(400, 2);
    endcase
  endfunction

  function automatic logic [DIM_REG_W-1:0] pick_center();
    case ($urandom_range(5))
      0:       return 11'h7FF;
      1:       return 11'h400 | $urandom_range(1023);
      2:       return 11'd1023;
      3:       return 11'd0;
      default: return $urandom_range(400);
    endcase
  endfunction

  task automatic flag(input string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endtask

  task automatic push_word(input logic [PIX_W-1:0] px, input int x, input int y);
    pending_words.push_back('{px, x[POS_W-1:0], y[POS_W-1:0]});
  endtask

  // Write one register; call just after a rising edge, returns on the accepting edge
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_EFFECT:    m_effect = effect_t'(val[1:0]);
      REG_DIRECTION: m_dir    = val[0];
      REG_PROGRESS:  m_prog   = val[Q_W-1:0];
      REG_CORNER:    m_corner = corner_t'(val[1:0]);
      REG_WIDTH:     m_width  = val;
      REG_HEIGHT:    m_height = val;
      REG_CENTER_X:  m_cx     = val;
      default:       m_cy     = val;
    endcase
  endtask

  // Load every register, then drop valid and move to the falling edge
  task automatic set_config(input effect_t e, input logic d, input logic [Q_W-1:0] p,
                            input corner_t c, input logic [10:0] w, input logic [10:0] h,
                            input logic [10:0] cx, input logic [10:0] cy);
    write_reg(REG_EFFECT, 11'(e));
    write_reg(REG_DIRECTION, 11'(d));
    write_reg(REG_PROGRESS, 11'(p));
    write_reg(REG_CORNER, 11'(c));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every word is in and every result is out, then let the pipe settle
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Drive pixel words from the pending queue and predict each accepted one
  always @(posedge clk) begin : drive_pixels
    pixel_word_t wd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_pixels.push_back(predict_pixel(in_pixel_in, in_x_pos, in_y_pos));
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          wd = pending_words.pop_front();
          in_pixel_in <= wd.px;
          in_x_pos    <= wd.x;
          in_y_pos    <= wd.y;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result word against the oldest prediction
  always @(posedge clk) begin : check_pixels
    logic [PIX_W-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          flag($sformatf("unexpected result word %h", out_pixel_out));
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_out !== want)
            flag($sformatf("pixel_out mismatch: expected %h, got %h", want, out_pixel_out));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count down a receiver hold-off
  always @(posedge clk) begin
    if (hold_ack_seq != hold_req_seq) begin
      hold_ack_seq <= hold_req_seq;
      hold_left    <= hold_len;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("screen_transition_pixel_effect_unit test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [Q_W-1:0] prog;
    pixel_word_t    wd;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults pass pixels through
    push_word(16'hFFFF, 0, 0);
    push_word(16'h0000, 1023, 1023);
    push_word(16'hA5A5, 5, 7);
    drain();

    // Fade out at zero progress keeps full scale; fade in with progress saturated
    set_config(EFFECT_FADE, 1'b0, 9'd0, CORNER_NW, 11'd240, 11'd240, 11'h7FF, 11'h7FF);
    push_word(16'hFFFF, 0, 0);
    push_word(16'h0841, 3, 4);
    drain();
    set_config(EFFECT_FADE, 1'b1, 9'd511, CORNER_NW, 11'd240, 11'd240, 11'h7FF, 11'h7FF);
    push_word(16'hFFFF, 10, 10);
    push_word(16'h1234, 20, 30);
    drain();

    // Iris out at zero radius clears everything, the centre included
    set_config(EFFECT_IRIS, 1'b0, 9'd256, CORNER_NW, 11'd240, 11'd240, 11'h7FF, 11'h7FF);
    push_word(16'hFFFF, 120, 120);
    push_word(16'hFFFF, 0, 0);
    drain();

    // Iris in at zero radius keeps only the centre; any negative centre means middle
    set_config(EFFECT_IRIS, 1'b1, 9'd0, CORNER_NW, 11'd240, 11'd240, 11'h400, 11'h7FF);
    push_word(16'hFFFF, 120, 120);
    push_word(16'hFFFF, 121, 120);
    drain();

    // Centre off the frame, frame size saturated at both ends
    set_config(EFFECT_IRIS, 1'b1, 9'd256, CORNER_SE, 11'd0, 11'd2047, 11'd1023, 11'd0);
    push_word(16'hFFFF, 0, 0);
    push_word(16'hFFFF, 1023, 1023);
    drain();

    // Wipe front at zero progress: out keeps, in clears
    set_config(EFFECT_WIPE, 1'b0, 9'd0, CORNER_NW, 11'd240, 11'd240, 11'h7FF, 11'h7FF);
    push_word(16'hFFFF, 0, 0);
    drain();
    set_config(EFFECT_WIPE, 1'b1, 9'd0, CORNER_SE, 11'd240, 11'd240, 11'h7FF, 11'h7FF);
    push_word(16'hFFFF, 239, 239);
    push_word(16'hFFFF, 0, 0);
    drain();

    // Wipe halves on the front, and both sides of it
    set_config(EFFECT_WIPE, 1'b1, 9'd128, CORNER_SW, 11'd240, 11'd240, 11'h7FF, 11'h7FF);
    push_word(16'hFFFF, 1, 0);
    push_word(16'hFFFF, 0, 0);
    drain();
    set_config(EFFECT_WIPE, 1'b0, 9'd256, CORNER_NE, 11'd240, 11'd240, 11'h7FF, 11'h7FF);
    push_word(16'hFFFF, 0, 1023);
    push_word(16'hFFFF, 239, 0);
    drain();

    // Random phases: every effect under every idling mode
    for (int ph = 0; ph < 16; ph++) begin
      case ($urandom_range(7))
        0:       prog = 9'd0;
        1:       prog = 9'd256;
        2:       prog = 9'd511;
        3:       prog = 9'd128;
        4:       prog = $urandom_range(511, 257);
        default: prog = $urandom_range(256);
      endcase
      set_config(effect_t'(ph % 4), 1'($urandom_range(1)), prog,
                 corner_t'($urandom_range(3)), pick_dim(), pick_dim(),
                 pick_center(), pick_center());
      case (ph / 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      // Hold the receiver off long enough for the pipe to back up into the input
      if (ph == 9) begin
        hold_len = 300;
        hold_req_seq++;
      end
      repeat (60) begin
        wd = make_word();
        pending_words.push_back(wd);
      end
      // Pause the sender until the pipe is empty, then continue with the same setting
      drain();
      @(negedge clk);
      repeat (60) begin
        wd = make_word();
        pending_words.push_back(wd);
      end
      drain();
    end

    if (expected_pixels.size() != 0)
      flag($sformatf("%0d result words never arrived", expected_pixels.size()));
    if (fail_count == 0)
      $display("screen_transition_pixel_effect_unit test passed");
    else
      $display("screen_transition_pixel_effect_unit test failed");
    $finish;
  end

endmodule
